>>> design/bsrf_pkg.sv
// Package for the burst sample ring FIFO: defaults, codes and state type.
`default_nettype none

package bsrf_pkg;

    localparam int DEF_RING_DEPTH   = 64;
    localparam int DEF_SAMPLE_WIDTH = 32;
    localparam int CFG_W            = 7;
    localparam int CNT_W            = 7;

    localparam logic [CFG_W-1:0] CAP_RESET = 7'd64;

    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_READ  = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_REJECT  = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_CLEARED = 2'd3
    } status_t;

    typedef enum logic {
        FSM_IDLE,
        FSM_READ
    } fsm_t;

endpackage

`default_nettype wire

>>> design/burst_sample_ring_fifo.sv
// Burst sample ring FIFO: all-or-nothing write bursts, counted read runs.
// Latency: the first result of a beat appears in the cycle after the beat is accepted.
// Write, clear and empty-read beats leave busy low.
// A read of N samples gives min(N, fill) results in consecutive cycles, busy
// high while the reads after the first are issued; one memory read per result.
// Reset (rst_n low, async) empties the queue, capacity returns to 64.
`default_nettype none

module burst_sample_ring_fifo
    import bsrf_pkg::*;
#(
    parameter int RING_DEPTH   = DEF_RING_DEPTH,
    parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic [1:0]              action,
    input  wire logic [SAMPLE_WIDTH-1:0] sample_bits,
    input  wire logic                    burst_first,
    input  wire logic [CNT_W-1:0]        count,
    input  wire logic                    cfg_we,
    input  wire logic [CFG_W-1:0]        cfg_data,
    output logic                         out_strobe,
    output logic [SAMPLE_WIDTH-1:0]      out_sample,
    output logic                         out_valid,
    output logic                         run_last,
    output logic [1:0]                   status,
    output logic [CNT_W-1:0]             fill_level
);

    localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CW    = (PTR_W + 1 > CFG_W) ? PTR_W + 1 : CFG_W;

    logic [SAMPLE_WIDTH-1:0] mem [RING_DEPTH];

    fsm_t             state_reg, state_next;
    logic [PTR_W-1:0] rp_reg, rp_next;
    logic [PTR_W-1:0] cp_reg, cp_next;
    logic [PTR_W-1:0] sp_reg, sp_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [CNT_W-1:0] brem_reg, brem_next;
    logic             brej_reg, brej_next;
    logic [CNT_W-1:0] open_reg, open_next;
    logic [CNT_W-1:0] rleft_reg, rleft_next;
    logic [CFG_W-1:0] cap_reg;
    logic             strobe_reg, strobe_next;
    logic             valid_reg, valid_next;
    logic             last_reg, last_next;
    status_t          status_reg, status_next;
    logic [SAMPLE_WIDTH-1:0] rd_data_reg;

    logic                    mem_we, mem_re;
    logic [PTR_W-1:0]        mem_waddr, mem_raddr;
    logic [CFG_W-1:0]        cap_eff;

    function automatic logic [PTR_W-1:0] adv(input logic [PTR_W-1:0] p,
                                             input logic [CFG_W-1:0] cap);
        logic [CW-1:0] n;
        n = CW'(p) + CW'(1);
        return (n >= CW'(cap)) ? '0 : n[PTR_W-1:0];
    endfunction

    always_comb
    begin
        if (cap_reg == '0)
            cap_eff = CFG_W'(1);
        else if (CW'(cap_reg) > CW'(RING_DEPTH))
            cap_eff = CFG_W'(RING_DEPTH);
        else
            cap_eff = cap_reg;
    end

    always_comb
    begin
        logic [CNT_W-1:0] space;
        logic [CNT_W-1:0] n_rd;
        logic [CNT_W-1:0] rem_v;
        logic [CNT_W-1:0] open_v;
        logic [PTR_W-1:0] sp_v;
        logic             do_store;

        state_next  = state_reg;
        rp_next     = rp_reg;
        cp_next     = cp_reg;
        sp_next     = sp_reg;
        fill_next   = fill_reg;
        brem_next   = brem_reg;
        brej_next   = brej_reg;
        open_next   = open_reg;
        rleft_next  = rleft_reg;
        strobe_next = 1'b0;
        valid_next  = 1'b0;
        last_next   = 1'b1;
        status_next = ST_OK;
        mem_we      = 1'b0;
        mem_waddr   = sp_reg;
        mem_re      = 1'b0;
        mem_raddr   = rp_reg;

        space    = (fill_reg >= cap_eff) ? '0 : cap_eff - fill_reg;
        n_rd     = (count < fill_reg) ? count : fill_reg;
        rem_v    = brem_reg;
        open_v   = open_reg;
        sp_v     = sp_reg;
        do_store = 1'b0;

        unique case (state_reg)
            FSM_IDLE:
            begin
                if (start)
                begin
                    unique case (action_t'(action))
                        ACT_WRITE:
                        begin
                            strobe_next = 1'b1;
                            if (burst_first)
                            begin
                                sp_v = cp_reg;
                                if (count == '0 || count > space)
                                begin
                                    brej_next   = (count != '0);
                                    rem_v       = (count != '0) ? count - CNT_W'(1) : '0;
                                    open_v      = '0;
                                    status_next = ST_REJECT;
                                end
                                else
                                begin
                                    brej_next = 1'b0;
                                    rem_v     = count;
                                    open_v    = count;
                                    do_store  = 1'b1;
                                end
                            end
                            else if (brem_reg == '0)
                            begin
                                status_next = ST_REJECT;
                            end
                            else if (brej_reg)
                            begin
                                rem_v = brem_reg - CNT_W'(1);
                                if (rem_v == '0)
                                    brej_next = 1'b0;
                                status_next = ST_REJECT;
                            end
                            else
                            begin
                                do_store = 1'b1;
                            end

                            if (do_store)
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = sp_v;
                                sp_v      = adv(sp_v, cap_eff);
                                rem_v     = rem_v - CNT_W'(1);
                                if (rem_v == '0)
                                begin
                                    cp_next   = sp_v;
                                    fill_next = fill_reg + open_v;
                                    open_v    = '0;
                                end
                            end
                            sp_next   = sp_v;
                            brem_next = rem_v;
                            open_next = open_v;
                        end
                        ACT_READ:
                        begin
                            strobe_next = 1'b1;
                            if (n_rd == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                valid_next = 1'b1;
                                last_next  = (n_rd == CNT_W'(1));
                                rp_next    = adv(rp_reg, cap_eff);
                                fill_next  = fill_reg - CNT_W'(1);
                                rleft_next = n_rd - CNT_W'(1);
                                if (n_rd != CNT_W'(1))
                                    state_next = FSM_READ;
                            end
                        end
                        ACT_CLEAR:
                        begin
                            strobe_next = 1'b1;
                            status_next = ST_CLEARED;
                            rp_next     = '0;
                            cp_next     = '0;
                            sp_next     = '0;
                            fill_next   = '0;
                            brem_next   = '0;
                            brej_next   = 1'b0;
                            open_next   = '0;
                        end
                        ACT_NONE:
                        begin
                            strobe_next = 1'b0;
                        end
                        default:
                        begin
                            strobe_next = 1'b0;
                        end
                    endcase
                end
            end
            FSM_READ:
            begin
                strobe_next = 1'b1;
                mem_re      = 1'b1;
                valid_next  = 1'b1;
                last_next   = (rleft_reg == CNT_W'(1));
                rp_next     = adv(rp_reg, cap_eff);
                fill_next   = fill_reg - CNT_W'(1);
                rleft_next  = rleft_reg - CNT_W'(1);
                if (rleft_reg == CNT_W'(1))
                    state_next = FSM_IDLE;
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= FSM_IDLE;
            rp_reg     <= '0;
            cp_reg     <= '0;
            sp_reg     <= '0;
            fill_reg   <= '0;
            brem_reg   <= '0;
            brej_reg   <= 1'b0;
            open_reg   <= '0;
            rleft_reg  <= '0;
            cap_reg    <= CAP_RESET;
            strobe_reg <= 1'b0;
            valid_reg  <= 1'b0;
            last_reg   <= 1'b0;
            status_reg <= ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            rp_reg     <= rp_next;
            cp_reg     <= cp_next;
            sp_reg     <= sp_next;
            fill_reg   <= fill_next;
            brem_reg   <= brem_next;
            brej_reg   <= brej_next;
            open_reg   <= open_next;
            rleft_reg  <= rleft_next;
            strobe_reg <= strobe_next;
            valid_reg  <= valid_next;
            last_reg   <= last_next;
            status_reg <= status_next;
            if (cfg_we)
                cap_reg <= cfg_data;
        end
    end

    // sample memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= sample_bits;
        if (mem_re)
            rd_data_reg <= mem[mem_raddr];
    end

    assign busy       = (state_reg == FSM_READ);
    assign out_strobe = strobe_reg;
    assign out_valid  = valid_reg;
    assign out_sample = valid_reg ? rd_data_reg : '0;
    assign run_last   = last_reg;
    assign status     = status_reg;
    assign fill_level = fill_reg;

endmodule

`default_nettype wire

>>> design/bsrf_checker.sv
// Port-level assertions for the burst sample ring FIFO, bound to the top level.
`default_nettype none

module bsrf_checker
    import bsrf_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             busy,
    input wire logic             out_strobe,
    input wire logic             out_valid,
    input wire logic             run_last,
    input wire logic [1:0]       status,
    input wire logic [CNT_W-1:0] fill_level
);

    // non-read results are single beats
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_strobe && !out_valid |-> run_last)
        else $error("non-read result without run_last");

    a_valid_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_strobe && status == ST_OK)
        else $error("read sample with bad status or no strobe");

    a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_strobe && status == ST_CLEARED |-> fill_level == '0)
        else $error("clear left data behind");

    a_busy_beat: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> out_strobe && out_valid && !run_last)
        else $error("busy without a running read");

    a_run_cont: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !run_last |=> out_valid && fill_level == $past(fill_level) - 7'd1)
        else $error("read run broke off early");

endmodule

bind burst_sample_ring_fifo bsrf_checker u_bsrf_checker (.*);

`default_nettype wire

>>> dv/burst_sample_ring_fifo_tb.sv
// Self-checking testbench for the burst sample ring FIFO: directed table, then random bursts.
`timescale 1ns / 1ps

module burst_sample_ring_fifo_tb;
    import bsrf_pkg::*;

    localparam int DEPTH       = DEF_RING_DEPTH;
    localparam int SW          = DEF_SAMPLE_WIDTH;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RAND_BEATS  = 340;
    localparam int PHASE_BEATS = 60;
    localparam int DIR_ROWS    = 25;

    typedef struct packed {
        logic [SW-1:0]    smp;
        logic             vld;
        logic             last;
        status_t          st;
        logic [CNT_W-1:0] fill;
    } fifo_out_t;

    typedef enum logic {
        ROW_BEAT,
        ROW_CFG
    } row_kind_t;

    typedef struct {
        row_kind_t        kind;
        action_t          act;
        logic [SW-1:0]    smp;
        logic             first;
        logic [CNT_W-1:0] cnt;
        bit               typed;
        status_t          st;
        logic [CNT_W-1:0] fill;
    } dir_row_t;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    logic [1:0]       action;
    logic [SW-1:0]    sample_bits;
    logic             burst_first;
    logic [CNT_W-1:0] count;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_data;
    logic             out_strobe;
    logic [SW-1:0]    out_sample;
    logic             out_valid;
    logic             run_last;
    logic [1:0]       status;
    logic [CNT_W-1:0] fill_level;

    // predicted queue state
    logic [SW-1:0] ring_mem [DEPTH];
    int            rd_ptr;
    int            cm_ptr;
    int            st_ptr;
    int            fill_cnt;
    int            burst_left;
    int            open_len;
    bit            burst_drop;
    int            cap_reg;

    fifo_out_t     outs_due [$];
    fifo_out_t     got_out;
    fifo_out_t     want_out;
    dir_row_t      dir_rows [DIR_ROWS];
    int            bad_count   = 0;
    int            beats_sent  = 0;
    int            cycle_count = 0;
    bit            no_idle     = 1'b0;

    burst_sample_ring_fifo i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .action      (action),
        .sample_bits (sample_bits),
        .burst_first (burst_first),
        .count       (count),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .out_strobe  (out_strobe),
        .out_sample  (out_sample),
        .out_valid   (out_valid),
        .run_last    (run_last),
        .status      (status),
        .fill_level  (fill_level)
    );

    initial clk = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT) @(posedge clk);
        $display("Test completed with failures");
        $finish;
    end

    function automatic int eff_cap();
        if (cap_reg == 0) return 1;
        if (cap_reg > DEPTH) return DEPTH;
        return cap_reg;
    endfunction

    function automatic int next_slot(int p);
        return (p + 1 >= eff_cap()) ? 0 : p + 1;
    endfunction

    function automatic int free_slots();
        return (fill_cnt >= eff_cap()) ? 0 : eff_cap() - fill_cnt;
    endfunction

    function automatic void push_out(logic [SW-1:0] s, logic v, logic l, status_t st);
        outs_due.push_back('{s, v, l, st, CNT_W'(fill_cnt)});
    endfunction

    function automatic void empty_queue();
        rd_ptr     = 0;
        cm_ptr     = 0;
        st_ptr     = 0;
        fill_cnt   = 0;
        burst_left = 0;
        open_len   = 0;
        burst_drop = 1'b0;
    endfunction

    function automatic void fifo_predict(action_t a, logic [SW-1:0] s, logic f,
                                         logic [CNT_W-1:0] c);
        int n;
        int i;
        case (a)
            ACT_WRITE:
            begin
                if (f) begin
                    // a new header always discards whatever is staged
                    st_ptr     = cm_ptr;
                    burst_left = 0;
                    open_len   = 0;
                    if (c == 0 || c > eff_cap() || c > free_slots()) begin
                        burst_drop = (c != 0);
                        burst_left = (c != 0) ? int'(c) - 1 : 0;
                        push_out('0, 1'b0, 1'b1, ST_REJECT);
                        return;
                    end
                    burst_drop = 1'b0;
                    burst_left = int'(c);
                    open_len   = int'(c);
                end else if (burst_left == 0) begin
                    push_out('0, 1'b0, 1'b1, ST_REJECT);
                    return;
                end else if (burst_drop) begin
                    burst_left--;
                    if (burst_left == 0) burst_drop = 1'b0;
                    push_out('0, 1'b0, 1'b1, ST_REJECT);
                    return;
                end
                ring_mem[st_ptr] = s;
                st_ptr = next_slot(st_ptr);
                burst_left--;
                if (burst_left == 0) begin
                    cm_ptr   = st_ptr;
                    fill_cnt = fill_cnt + open_len;
                    open_len = 0;
                end
                push_out('0, 1'b0, 1'b1, ST_OK);
            end
            ACT_READ:
            begin
                n = (int'(c) < fill_cnt) ? int'(c) : fill_cnt;
                if (n == 0) push_out('0, 1'b0, 1'b1, ST_EMPTY);
                for (i = 0; i < n; i++) begin
                    s = ring_mem[rd_ptr];
                    rd_ptr = next_slot(rd_ptr);
                    fill_cnt--;
                    push_out(s, 1'b1, i == n - 1, ST_OK);
                end
            end
            ACT_CLEAR:
            begin
                empty_queue();
                push_out('0, 1'b0, 1'b1, ST_CLEARED);
            end
            default:
            begin
            end
        endcase
    endfunction

    task automatic report_bad(string what, fifo_out_t want, fifo_out_t got);
        bad_count++;
        if (bad_count <= 10)
            $display({"%0t %s: exp smp=%h vld=%b last=%b st=%0d fill=%0d",
                      " | got smp=%h vld=%b last=%b st=%0d fill=%0d"},
                     $time, what, want.smp, want.vld, want.last, want.st, want.fill,
                     got.smp, got.vld, got.last, got.st, got.fill);
    endtask

    always @(negedge clk)
    begin
        if (rst_n && out_strobe) begin
            got_out = '{out_sample, out_valid, run_last, status_t'(status), fill_level};
            if (outs_due.size() == 0) begin
                report_bad("result beat with nothing expected", '0, got_out);
            end else begin
                want_out = outs_due.pop_front();
                if (got_out.smp !== want_out.smp || got_out.vld !== want_out.vld ||
                    got_out.last !== want_out.last || got_out.st !== want_out.st ||
                    got_out.fill !== want_out.fill)
                    report_bad("result mismatch", want_out, got_out);
            end
        end
    end

    task automatic send_beat(action_t a, logic [SW-1:0] s, logic f, logic [CNT_W-1:0] c);
        bit taken;
        if (!no_idle && $urandom_range(0, 4) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        start       <= 1'b1;
        action      <= a;
        sample_bits <= s;
        burst_first <= f;
        count       <= c;
        taken = 1'b0;
        while (!taken) begin
            @(negedge clk);
            taken = !busy;
            if (taken) fifo_predict(a, s, f, c);
            @(posedge clk);
        end
        if (a != ACT_NONE) beats_sent++;
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (outs_due.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_capacity(logic [CFG_W-1:0] v);
        drain_results();
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we  <= 1'b0;
        cap_reg = int'(v);
    endtask

    // hdr is the length announced; beats below hdr leave the burst open
    task automatic send_burst(int hdr, int beats, bit mid_read);
        int i;
        for (i = 0; i < beats; i++) begin
            if (mid_read && i == beats / 2)
                send_beat(ACT_READ, SW'($urandom), 1'b0, CNT_W'($urandom_range(0, 8)));
            send_beat(ACT_WRITE, SW'($urandom), i == 0,
                      (i == 0) ? CNT_W'(hdr) : CNT_W'($urandom_range(0, 127)));
        end
    endtask

    function automatic logic [CFG_W-1:0] pick_capacity();
        case ($urandom_range(0, 6))
            0:       return CFG_W'(1);
            1:       return CFG_W'(2);
            2:       return CFG_W'(64);
            3:       return CFG_W'(0);
            4:       return CFG_W'(127);
            5:       return CFG_W'($urandom_range(3, 63));
            default: return CFG_W'($urandom_range(65, 126));
        endcase
    endfunction

    task automatic random_phase();
        int target;
        int r;
        int room;
        int len;
        target = beats_sent + PHASE_BEATS;
        while (beats_sent < target) begin
            r    = $urandom_range(0, 99);
            room = free_slots();
            if (r < 45) begin
                if (room == 0) len = $urandom_range(1, 8);
                else if ($urandom_range(0, 7) == 0) len = room;
                else len = $urandom_range(1, (room < 12) ? room : 12);
                send_burst(len, ($urandom_range(0, 9) == 0) ? $urandom_range(1, len) : len,
                           $urandom_range(0, 9) == 0);
            end else if (r < 75) begin
                send_beat(ACT_READ, SW'($urandom), 1'($urandom_range(0, 1)),
                          ($urandom_range(0, 3) == 0) ? CNT_W'($urandom_range(0, 127))
                                                      : CNT_W'($urandom_range(1, fill_cnt + 1)));
            end else if (r < 82) begin
                send_beat(ACT_CLEAR, SW'($urandom), 1'($urandom_range(0, 1)),
                          CNT_W'($urandom_range(0, 127)));
            end else if (r < 88) begin
                send_beat(ACT_WRITE, SW'($urandom), 1'b0, CNT_W'($urandom_range(0, 127)));
            end else if (r < 92) begin
                send_beat(ACT_NONE, SW'($urandom), 1'($urandom_range(0, 1)),
                          CNT_W'($urandom_range(0, 127)));
            end else begin
                send_beat(ACT_WRITE, SW'($urandom), 1'b1,
                          ($urandom_range(0, 1) == 0) ? CNT_W'(0)
                                                      : CNT_W'($urandom_range(eff_cap() + 1, 127)));
            end
        end
    endtask

    initial
    begin
        int rand_goal;
        int k;

        rst_n       <= 1'b0;
        start       <= 1'b0;
        action      <= ACT_NONE;
        sample_bits <= '0;
        burst_first <= 1'b0;
        count       <= '0;
        cfg_we      <= 1'b0;
        cfg_data    <= '0;
        empty_queue();
        cap_reg = int'(CAP_RESET);

        dir_rows = '{
            '{ROW_BEAT, ACT_READ,  32'h0000_0000, 1'b0, 7'd4,   1'b1, ST_EMPTY,   7'd0},
            '{ROW_BEAT, ACT_WRITE, 32'h0000_0000, 1'b0, 7'd1,   1'b1, ST_REJECT,  7'd0},
            '{ROW_BEAT, ACT_WRITE, 32'h0000_0000, 1'b1, 7'd0,   1'b1, ST_REJECT,  7'd0},
            '{ROW_BEAT, ACT_WRITE, 32'h1111_1111, 1'b1, 7'd65,  1'b1, ST_REJECT,  7'd0},
            '{ROW_BEAT, ACT_WRITE, 32'h2222_2222, 1'b0, 7'd127, 1'b1, ST_REJECT,  7'd0},
            '{ROW_BEAT, ACT_WRITE, 32'hFFFF_FFFF, 1'b1, 7'd3,   1'b1, ST_OK,      7'd0},
            '{ROW_BEAT, ACT_WRITE, 32'h0000_0000, 1'b0, 7'd0,   1'b1, ST_OK,      7'd0},
            '{ROW_BEAT, ACT_WRITE, 32'hA5A5_A5A5, 1'b0, 7'd3,   1'b1, ST_OK,      7'd3},
            '{ROW_BEAT, ACT_READ,  32'h0000_0000, 1'b0, 7'd2,   1'b0, ST_OK,      7'd0},
            '{ROW_BEAT, ACT_WRITE, 32'h1234_5678, 1'b1, 7'd2,   1'b1, ST_OK,      7'd1},
            '{ROW_BEAT, ACT_WRITE, 32'h8000_0001, 1'b1, 7'd1,   1'b1, ST_OK,      7'd2},
            '{ROW_BEAT, ACT_READ,  32'hFFFF_FFFF, 1'b1, 7'd127, 1'b0, ST_OK,      7'd0},
            '{ROW_BEAT, ACT_READ,  32'h0000_0000, 1'b0, 7'd0,   1'b1, ST_EMPTY,   7'd0},
            '{ROW_BEAT, ACT_WRITE, 32'h5A5A_5A5A, 1'b1, 7'd2,   1'b1, ST_OK,      7'd0},
            '{ROW_BEAT, ACT_WRITE, 32'h7FFF_FFFF, 1'b0, 7'd64,  1'b1, ST_OK,      7'd2},
            '{ROW_BEAT, ACT_NONE,  32'hFFFF_FFFF, 1'b1, 7'd127, 1'b0, ST_OK,      7'd0},
            '{ROW_BEAT, ACT_CLEAR, 32'h0000_0000, 1'b0, 7'd0,   1'b1, ST_CLEARED, 7'd0},
            '{ROW_BEAT, ACT_READ,  32'h0000_0000, 1'b0, 7'd1,   1'b1, ST_EMPTY,   7'd0},
            '{ROW_CFG,  ACT_NONE,  32'h0000_0000, 1'b0, 7'd0,   1'b0, ST_OK,      7'd0},
            '{ROW_BEAT, ACT_WRITE, 32'hDEAD_BEEF, 1'b1, 7'd1,   1'b1, ST_OK,      7'd1},
            '{ROW_BEAT, ACT_WRITE, 32'h3333_3333, 1'b1, 7'd1,   1'b1, ST_REJECT,  7'd1},
            '{ROW_BEAT, ACT_READ,  32'h0000_0000, 1'b0, 7'd64,  1'b0, ST_OK,      7'd0},
            '{ROW_CFG,  ACT_NONE,  32'h0000_0000, 1'b0, 7'd127, 1'b0, ST_OK,      7'd0},
            '{ROW_BEAT, ACT_WRITE, 32'h4444_4444, 1'b1, 7'd65,  1'b1, ST_REJECT,  7'd0},
            '{ROW_BEAT, ACT_CLEAR, 32'h0000_0000, 1'b0, 7'd0,   1'b1, ST_CLEARED, 7'd0}
        };

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (k = 0; k < DIR_ROWS; k++) begin
            if (dir_rows[k].kind == ROW_CFG) begin
                set_capacity(dir_rows[k].cnt);
            end else begin
                send_beat(dir_rows[k].act, dir_rows[k].smp, dir_rows[k].first, dir_rows[k].cnt);
                if (dir_rows[k].typed)
                    outs_due[outs_due.size() - 1] =
                        '{'0, 1'b0, 1'b1, dir_rows[k].st, dir_rows[k].fill};
            end
        end

        // fill every slot once at full capacity so later shrinks never expose stale slots
        rand_goal = beats_sent + RAND_BEATS;
        set_capacity(CFG_W'(64));
        send_beat(ACT_CLEAR, '0, 1'b0, '0);
        send_burst(DEPTH, DEPTH, 1'b0);
        send_beat(ACT_READ, '0, 1'b0, CNT_W'(DEPTH));

        while (beats_sent < rand_goal) begin
            if (beats_sent >= rand_goal - 80) no_idle = 1'b1;
            set_capacity(pick_capacity());
            random_phase();
        end

        drain_results();
        repeat (8) @(posedge clk);
        bad_count = bad_count + outs_due.size();
        if (bad_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
